// ===== hdl/mpd_pkg.sv =====
// Package for the mesh packet decoder: payload structs, codes and sizes.
// Depends on nothing; every module of the block imports it.
package mpd_pkg;

  localparam int MaxPayloadBytes = 256;
  localparam int MaxPacketBytes  = 512;

  typedef enum logic [1:0] {
    KIND_FIELD = 2'd0,
    KIND_START = 2'd1,
    KIND_BYTE  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_LONG     = 3'd2;
  localparam logic [2:0] ST_WIRETYPE = 3'd3;
  localparam logic [2:0] ST_PAYLOAD  = 3'd4;
  localparam logic [2:0] ST_OVERRUN  = 3'd5;

  localparam logic [3:0] FC_FROM = 4'd0;
  localparam logic [3:0] FC_TO   = 4'd1;
  localparam logic [3:0] FC_ID   = 4'd2;
  localparam logic [3:0] FC_RXT  = 4'd3;
  localparam logic [3:0] FC_SNR  = 4'd4;
  localparam logic [3:0] FC_HOP  = 4'd5;
  localparam logic [3:0] FC_ACK  = 4'd6;
  localparam logic [3:0] FC_RSSI = 4'd7;
  localparam logic [3:0] FC_PORT = 4'd8;
  localparam logic [3:0] FC_PLEN = 4'd9;
  localparam logic [3:0] FC_WANT = 4'd10;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  field_code;
    logic [31:0] value;
    logic [2:0]  status;
    logic        final_item;
  } out_item_t;

  // Work produced by one byte: up to two result items.
  typedef struct packed {
    logic      has_a;
    out_item_t item_a;
    logic      has_b;
    out_item_t item_b;
  } job_t;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

endpackage

// ===== hdl/mesh_packet_protobuf_decoder_core.sv =====
// Mesh packet protobuf decoder, top level: parser front, job queue, output back.
// Each result is written into the job queue before it is offered on the output.
// Throughput: one byte per cycle while the job queue is not full; a byte giving two results makes two output transfers.
// Bytes giving no result are dropped by the parser and use no queue slot.
// Reset (rst_n low, synchronous) clears parser state and empties the queue.
module mesh_packet_protobuf_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mpd_pkg::out_item_t out_data
);
  import mpd_pkg::*;

  job_t job, head;
  logic full, empty, pop, take;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  mpd_front u_front (.clk, .rst_n, .take, .item(in_data), .job);

  mpd_queue u_queue (
    .clk, .rst_n, .push(take && (job.has_a || job.has_b)), .push_job(job),
    .full, .pop, .empty, .head
  );

  mpd_back u_back (.clk, .rst_n, .empty, .head, .pop, .out_valid, .out_ready, .out_data);
endmodule

// ===== hdl/mpd_front.sv =====
// Front end: the byte-serial protobuf parser producing one job per byte.
// Depends on mpd_pkg.
module mpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  mpd_pkg::in_item_t item,
  output mpd_pkg::job_t     job
);
  import mpd_pkg::*;

  typedef enum logic [5:0] {
    PH_TAG     = 6'b000001,
    PH_VARINT  = 6'b000010,
    PH_FIXED   = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_SKIP    = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] vacc_r, vacc_nxt;
  logic [3:0]  vcnt_r, vcnt_nxt;
  logic [31:0] facc_r, facc_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [31:0] field_r, field_nxt;
  logic        inside_r, inside_nxt;
  logic [9:0]  nest_r, nest_nxt;
  logic [9:0]  skip_r, skip_nxt;
  logic [8:0]  pay_r, pay_nxt;
  logic [2:0]  err_r, err_nxt;

  // Merged varint value including the current byte.
  logic [63:0] vfull;
  logic [6:0]  vshift;
  logic [63:0] vpart;
  logic [60:0] fnum;
  logic [2:0]  wt;
  logic        vlen_big;
  logic [2:0]  st;

  function automatic out_item_t mk(kind_t k, logic [3:0] c, logic [31:0] v);
    out_item_t o;
    o.kind = k;
    o.field_code = c;
    o.value = v;
    o.status = ST_OK;
    o.final_item = 1'b0;
    return o;
  endfunction

  always_comb begin
    vshift = 7'({3'd0, vcnt_r} * 7);
    vpart  = (vshift < 7'd64) ? ({57'd0, item.byte_in[6:0]} << vshift[5:0]) : 64'd0;
    vfull  = vacc_r | vpart;
    fnum   = vfull[63:3];
    wt     = vfull[2:0];
    vlen_big = (vfull > 64'(MaxPacketBytes));
  end

  // Next-state logic for one byte.
  always_comb begin
    logic was_inside;
    phase_nxt  = phase_r;
    vacc_nxt   = vacc_r;
    vcnt_nxt   = vcnt_r;
    facc_nxt   = facc_r;
    fcnt_nxt   = fcnt_r;
    field_nxt  = field_r;
    inside_nxt = inside_r;
    nest_nxt   = nest_r;
    skip_nxt   = skip_r;
    pay_nxt    = pay_r;
    err_nxt    = err_r;
    job        = '0;
    was_inside = inside_r;
    st         = ST_OK;

    if (err_r == ST_OK) begin
      if (was_inside && nest_r != 10'd0) nest_nxt = nest_r - 10'd1;
      unique case (phase_r)
        PH_TAG, PH_VARINT, PH_LEN: begin
          vacc_nxt = vfull;
          vcnt_nxt = vcnt_r + 4'd1;
          if (item.byte_in[7] && vcnt_r >= 4'd9) begin
            err_nxt = ST_LONG;
          end else if (!item.byte_in[7]) begin
            vacc_nxt  = '0;
            vcnt_nxt  = '0;
            phase_nxt = PH_TAG;
            if (phase_r == PH_TAG) begin
              // Tag complete: choose how to read the field.
              field_nxt = (fnum[60:32] != '0) ? 32'd0 : fnum[31:0];
              if (!inside_r) begin
                priority case (field_nxt)
                  32'd1, 32'd2, 32'd6, 32'd7, 32'd8: begin
                    facc_nxt = '0;
                    fcnt_nxt = '0;
                    phase_nxt = PH_FIXED;
                  end
                  32'd3, 32'd9, 32'd10, 32'd12: phase_nxt = PH_VARINT;
                  32'd4: if (wt == 3'd2) phase_nxt = PH_LEN; else err_nxt = ST_WIRETYPE;
                  default: begin
                    priority case (wt)
                      3'd0: phase_nxt = PH_VARINT;
                      3'd1: begin skip_nxt = 10'd8; phase_nxt = PH_SKIP; end
                      3'd2: phase_nxt = PH_LEN;
                      3'd5: begin skip_nxt = 10'd4; phase_nxt = PH_SKIP; end
                      default: err_nxt = ST_WIRETYPE;
                    endcase
                  end
                endcase
              end else begin
                priority case (field_nxt)
                  32'd1, 32'd3: phase_nxt = PH_VARINT;
                  32'd2: if (wt == 3'd2) phase_nxt = PH_LEN; else err_nxt = ST_WIRETYPE;
                  default: begin
                    priority case (wt)
                      3'd0: phase_nxt = PH_VARINT;
                      3'd1: begin skip_nxt = 10'd8; phase_nxt = PH_SKIP; end
                      3'd2: phase_nxt = PH_LEN;
                      3'd5: begin skip_nxt = 10'd4; phase_nxt = PH_SKIP; end
                      default: err_nxt = ST_WIRETYPE;
                    endcase
                  end
                endcase
              end
            end else if (phase_r == PH_VARINT) begin
              // Varint value complete.
              if (!inside_r) begin
                if (field_r == 32'd9) begin
                  job.has_a = 1'b1; job.item_a = mk(KIND_FIELD, FC_HOP, vfull[31:0]);
                end else if (field_r == 32'd10) begin
                  job.has_a = 1'b1;
                  job.item_a = mk(KIND_FIELD, FC_ACK, {31'd0, vfull != 64'd0});
                end else if (field_r == 32'd12) begin
                  job.has_a = 1'b1; job.item_a = mk(KIND_FIELD, FC_RSSI, vfull[31:0]);
                end
              end else begin
                if (field_r == 32'd1) begin
                  job.has_a = 1'b1; job.item_a = mk(KIND_FIELD, FC_PORT, vfull[31:0]);
                end else if (field_r == 32'd3) begin
                  job.has_a = 1'b1;
                  job.item_a = mk(KIND_FIELD, FC_WANT, {31'd0, vfull != 64'd0});
                end
              end
            end else begin
              // Length prefix complete, checked against the bytes left after this one.
              if (inside_r && vfull > {54'd0, nest_nxt}) begin
                err_nxt = ST_OVERRUN;
              end else if (vlen_big) begin
                err_nxt = ST_TRUNC;
              end else if (!inside_r && field_r == 32'd4) begin
                job.has_a = 1'b1; job.item_a = mk(KIND_START, 4'd0, 32'd0);
                if (vfull != 64'd0) begin
                  inside_nxt = 1'b1;
                  nest_nxt = vfull[9:0];
                end
              end else if (inside_r && field_r == 32'd2) begin
                if (vfull > 64'(MaxPayloadBytes)) begin
                  err_nxt = ST_PAYLOAD;
                end else begin
                  job.has_a = 1'b1;
                  job.item_a = mk(KIND_FIELD, FC_PLEN, vfull[31:0]);
                  pay_nxt = vfull[8:0];
                  if (vfull != 64'd0) phase_nxt = PH_PAYLOAD;
                end
              end else if (vfull != 64'd0) begin
                skip_nxt = vfull[9:0];
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_FIXED: begin
          facc_nxt = facc_r | ({24'd0, item.byte_in} << {fcnt_r[1:0], 3'd0});
          fcnt_nxt = fcnt_r + 3'd1;
          if (fcnt_nxt >= 3'd4) begin
            job.has_a = 1'b1;
            priority case (field_r)
              32'd2:   job.item_a = mk(KIND_FIELD, FC_TO, facc_nxt);
              32'd6:   job.item_a = mk(KIND_FIELD, FC_ID, facc_nxt);
              32'd7:   job.item_a = mk(KIND_FIELD, FC_RXT, facc_nxt);
              32'd8:   job.item_a = mk(KIND_FIELD, FC_SNR, facc_nxt);
              default: job.item_a = mk(KIND_FIELD, FC_FROM, facc_nxt);
            endcase
            phase_nxt = PH_TAG;
          end
        end
        PH_SKIP: begin
          if (skip_r != 10'd0) skip_nxt = skip_r - 10'd1;
          if (skip_nxt == 10'd0) phase_nxt = PH_TAG;
        end
        PH_PAYLOAD: begin
          job.has_a = 1'b1;
          job.item_a = mk(KIND_BYTE, 4'd0, {24'd0, item.byte_in});
          if (pay_r != 9'd0) pay_nxt = pay_r - 9'd1;
          if (pay_nxt == 9'd0) phase_nxt = PH_TAG;
        end
        default: phase_nxt = PH_TAG;
      endcase
      // Nested message boundary.
      if (was_inside && err_nxt == ST_OK && nest_nxt == 10'd0) begin
        if (phase_nxt == PH_TAG && vcnt_nxt == 4'd0) inside_nxt = 1'b0;
        else err_nxt = ST_OVERRUN;
      end
    end

    // End status closes the packet and returns to reset state.
    if (item.end_of_packet) begin
      st = err_nxt;
      if (st == ST_OK && (inside_nxt || phase_nxt != PH_TAG || vcnt_nxt != 4'd0))
        st = ST_TRUNC;
      job.has_b = 1'b1;
      job.item_b = mk(KIND_END, 4'd0, 32'd0);
      job.item_b.status = st;
      job.item_b.final_item = 1'b1;
      phase_nxt = PH_TAG; vacc_nxt = '0; vcnt_nxt = '0; facc_nxt = '0;
      fcnt_nxt = '0; field_nxt = '0; inside_nxt = 1'b0; nest_nxt = '0;
      skip_nxt = '0; pay_nxt = '0; err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG; vacc_r <= '0; vcnt_r <= '0; facc_r <= '0;
      fcnt_r <= '0; field_r <= '0; inside_r <= 1'b0; nest_r <= '0;
      skip_r <= '0; pay_r <= '0; err_r <= ST_OK;
    end else if (take) begin
      phase_r <= phase_nxt; vacc_r <= vacc_nxt; vcnt_r <= vcnt_nxt;
      facc_r <= facc_nxt; fcnt_r <= fcnt_nxt; field_r <= field_nxt;
      inside_r <= inside_nxt; nest_r <= nest_nxt; skip_r <= skip_nxt;
      pay_r <= pay_nxt; err_r <= err_nxt;
    end
  end
endmodule

// ===== hdl/mpd_queue.sv =====
// Short job queue between the parser and the output sequencer.
// Depends on mpd_pkg.
module mpd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mpd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output mpd_pkg::job_t head
);
  import mpd_pkg::*;

  job_t             mem_r [QueueDepth];
  logic [QueueAw-1:0] wp_r, rp_r;
  logic [QueueAw:0]   cnt_r;

  assign full  = (cnt_r == (QueueAw+1)'(QueueDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  // Pointer and fill count update per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// ===== hdl/mpd_back.sv =====
// Back end: unpacks each job into its result items onto the output channel.
// Depends on mpd_pkg.
module mpd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  mpd_pkg::job_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mpd_pkg::out_item_t out_data
);
  import mpd_pkg::*;

  // Set once the first item of a two-item job has been transferred.
  logic half_r;
  logic first_is_a, two;

  assign first_is_a = head.has_a && !half_r;
  assign two        = head.has_a && head.has_b;
  assign out_valid  = !empty;
  assign out_data   = first_is_a ? head.item_a : head.item_b;
  assign pop        = out_valid && out_ready && !(two && !half_r);

  always_ff @(posedge clk) begin
    if (!rst_n) half_r <= 1'b0;
    else if (out_valid && out_ready) half_r <= two && !half_r;
  end
endmodule

// ===== bench/mpd_checker.sv =====
// Checker for the mesh packet decoder: watches both channels, predicts results, compares.
// Depends on mpd_pkg for the payload structs and the field, kind and status codes.
`timescale 1ns / 100ps
module mpd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  mpd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  mpd_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import mpd_pkg::*;

  typedef enum logic [2:0] {
    P_TAG, P_VARINT, P_FIXED, P_LEN, P_SKIP, P_PAYLOAD
  } phase_t;

  // Copy of the decoder state.
  phase_t      ph;
  logic [63:0] vacc;
  int unsigned vseen;
  logic [31:0] facc;
  int unsigned fseen;
  logic [31:0] fld;
  logic [2:0]  wt;
  logic        in_msg;
  int unsigned nleft;
  int unsigned sleft;
  int unsigned pleft;
  logic [2:0]  err;

  out_item_t expected_items[$];

  assign pending = expected_items.size();

  task automatic clear_state();
    ph = P_TAG; vacc = '0; vseen = 0; facc = '0; fseen = 0; fld = '0; wt = '0;
    in_msg = 1'b0; nleft = 0; sleft = 0; pleft = 0; err = ST_OK;
  endtask

  task automatic push_item(logic [1:0] k, logic [3:0] fc, logic [31:0] v,
                           logic [2:0] st, logic fin);
    out_item_t it;
    it.kind = k; it.field_code = fc; it.value = v; it.status = st; it.final_item = fin;
    expected_items.push_back(it);
  endtask

  task automatic skip_wire(logic [2:0] w);
    case (w)
      3'd0: ph = P_VARINT;
      3'd1: begin sleft = 8; ph = P_SKIP; end
      3'd2: ph = P_LEN;
      3'd5: begin sleft = 4; ph = P_SKIP; end
      default: err = ST_WIRETYPE;
    endcase
  endtask

  task automatic tag_complete();
    logic [63:0] fnum;
    fnum = vacc >> 3;
    wt = vacc[2:0];
    fld = (fnum > 64'hFFFF_FFFF) ? 32'd0 : fnum[31:0];
    ph = P_TAG;
    if (!in_msg) begin
      case (fld)
        1, 2, 6, 7, 8: begin facc = '0; fseen = 0; ph = P_FIXED; end
        3, 9, 10, 12: ph = P_VARINT;
        4: if (wt == 3'd2) ph = P_LEN; else err = ST_WIRETYPE;
        default: skip_wire(wt);
      endcase
    end else begin
      case (fld)
        1, 3: ph = P_VARINT;
        2: if (wt == 3'd2) ph = P_LEN; else err = ST_WIRETYPE;
        default: skip_wire(wt);
      endcase
    end
  endtask

  task automatic value_complete();
    logic [31:0] flag;
    flag = (vacc != 0) ? 32'd1 : 32'd0;
    ph = P_TAG;
    if (!in_msg) begin
      case (fld)
        9:  push_item(KIND_FIELD, FC_HOP, vacc[31:0], ST_OK, 1'b0);
        10: push_item(KIND_FIELD, FC_ACK, flag, ST_OK, 1'b0);
        12: push_item(KIND_FIELD, FC_RSSI, vacc[31:0], ST_OK, 1'b0);
        default: ;
      endcase
    end else begin
      case (fld)
        1: push_item(KIND_FIELD, FC_PORT, vacc[31:0], ST_OK, 1'b0);
        3: push_item(KIND_FIELD, FC_WANT, flag, ST_OK, 1'b0);
        default: ;
      endcase
    end
  endtask

  task automatic length_complete();
    ph = P_TAG;
    if (in_msg && vacc > nleft) begin
      err = ST_OVERRUN;
    end else if (vacc > MaxPacketBytes) begin
      err = ST_TRUNC;
    end else if (!in_msg && fld == 4) begin
      push_item(KIND_START, FC_FROM, '0, ST_OK, 1'b0);
      if (vacc != 0) begin in_msg = 1'b1; nleft = vacc[31:0]; end
    end else if (in_msg && fld == 2) begin
      if (vacc > MaxPayloadBytes) begin
        err = ST_PAYLOAD;
      end else begin
        push_item(KIND_FIELD, FC_PLEN, vacc[31:0], ST_OK, 1'b0);
        pleft = vacc[31:0];
        if (vacc != 0) ph = P_PAYLOAD;
      end
    end else if (vacc != 0) begin
      sleft = vacc[31:0]; ph = P_SKIP;
    end
  endtask

  task automatic consume_byte(logic [7:0] b);
    phase_t was;
    logic [3:0] code;
    case (ph)
      P_TAG, P_VARINT, P_LEN: begin
        if (7 * vseen < 64) vacc = vacc | (64'(b[6:0]) << (7 * vseen));
        vseen++;
        if (!b[7]) begin
          was = ph;
          if (was == P_TAG) tag_complete();
          else if (was == P_VARINT) value_complete();
          else length_complete();
          vacc = '0; vseen = 0;
        end else if (vseen >= 10) begin
          err = ST_LONG;
        end
      end
      P_FIXED: begin
        facc = facc | (32'(b) << (8 * (fseen % 4)));
        fseen++;
        if (fseen >= 4) begin
          case (fld)
            2: code = FC_TO;
            6: code = FC_ID;
            7: code = FC_RXT;
            8: code = FC_SNR;
            default: code = FC_FROM;
          endcase
          push_item(KIND_FIELD, code, facc, ST_OK, 1'b0);
          ph = P_TAG;
        end
      end
      P_SKIP: begin
        if (sleft > 0) sleft--;
        if (sleft == 0) ph = P_TAG;
      end
      default: begin
        push_item(KIND_BYTE, FC_FROM, 32'(b), ST_OK, 1'b0);
        if (pleft > 0) pleft--;
        if (pleft == 0) ph = P_TAG;
      end
    endcase
  endtask

  // Predict the results of one accepted input transfer.
  task automatic predict_byte(in_item_t it);
    logic was_in;
    logic [2:0] st;
    if (err == ST_OK) begin
      was_in = in_msg;
      if (was_in && nleft > 0) nleft--;
      consume_byte(it.byte_in);
      if (was_in && err == ST_OK && nleft == 0) begin
        if (ph == P_TAG && vseen == 0) in_msg = 1'b0;
        else err = ST_OVERRUN;
      end
    end
    if (it.end_of_packet) begin
      st = err;
      if (st == ST_OK && (in_msg || ph != P_TAG || vseen != 0)) st = ST_TRUNC;
      push_item(KIND_END, FC_FROM, '0, st, 1'b1);
      clear_state();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fail_count = 0;
      clear_state();
      expected_items.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_items.size() == 0) begin
          report_mismatch("unexpected result", {27'd0, out_data.kind, out_data.status},
                          32'd0);
        end else begin
          want = expected_items.pop_front();
          if (out_data.kind != want.kind)
            report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
          if (out_data.field_code != want.field_code)
            report_mismatch("field_code", 32'(out_data.field_code), 32'(want.field_code));
          if (out_data.value != want.value)
            report_mismatch("value", out_data.value, want.value);
          if (out_data.status != want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.final_item != want.final_item)
            report_mismatch("final_item", 32'(out_data.final_item), 32'(want.final_item));
        end
      end
      if (in_valid && in_ready) predict_byte(in_data);
    end
  end

  final_check : assert property (@(posedge clk) 1'b1);
endmodule

// ===== bench/tb_mesh_packet_protobuf_decoder_core.sv =====
// Testbench top for the mesh packet decoder: clock, reset, packet stimulus and verdict.
// Depends on mpd_pkg, mpd_checker and the block mesh_packet_protobuf_decoder_core.
`timescale 1ns / 100ps
module tb_mesh_packet_protobuf_decoder_core;
  import mpd_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycle_count;
  int        hold_off;
  bit        stim_done;

  logic [7:0] pkt[$];

  mesh_packet_protobuf_decoder_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  mpd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls, with one long hold-off early in the run.
  initial begin
    int gap;
    out_ready = 1'b0;
    hold_off = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    repeat (30) @(negedge clk);
    hold_off = 200;
    while (hold_off > 0) begin
      @(negedge clk);
      hold_off--;
    end
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stim_done) gap = 0;
      out_ready = 1'b0;
      repeat (gap) @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Byte helpers for building packets.
  task automatic put_varint(logic [63:0] v);
    do begin
      pkt.push_back({(v >> 7) != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endtask

  task automatic put_tag(int unsigned f, int unsigned w);
    put_varint((64'(f) << 3) | 64'(w));
  endtask

  task automatic put_fixed(logic [31:0] v);
    for (int i = 0; i < 4; i++) pkt.push_back(v[8 * i +: 8]);
  endtask

  // Send the packet held in pkt, one transfer per byte, random gaps between.
  task automatic send_packet();
    int gap;
    int n;
    in_item_t nxt;
    n = pkt.size();
    for (int i = 0; i < n; i++) begin
      gap = (hold_off > 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      nxt.byte_in = pkt[i];
      nxt.end_of_packet = (i == n - 1);
      in_valid <= 1'b1;
      in_data <= nxt;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    pkt.delete();
  endtask

  // A well-formed data message with random content.
  task automatic build_data(int unsigned plen);
    logic [7:0] inner[$];
    logic [7:0] outer[$];
    outer = pkt;
    pkt.delete();
    put_tag(1, 0); put_varint(64'($urandom_range(0, 600)));
    put_tag(2, 2); put_varint(64'(plen));
    for (int i = 0; i < plen; i++) pkt.push_back(8'($urandom));
    if ($urandom_range(0, 1)) begin put_tag(3, 0); put_varint(64'($urandom_range(0, 1))); end
    if ($urandom_range(0, 3) == 0) begin put_tag(5, 5); put_fixed($urandom); end
    inner = pkt;
    pkt = outer;
    put_tag(4, 2); put_varint(64'(inner.size()));
    foreach (inner[i]) pkt.push_back(inner[i]);
  endtask

  task automatic build_random_packet();
    int fields;
    int sel;
    fields = $urandom_range(1, 8);
    for (int k = 0; k < fields; k++) begin
      sel = $urandom_range(0, 13);
      case (sel)
        0, 1, 2: begin
          put_tag(($urandom_range(0, 4) == 0) ? 1 :
                  ($urandom_range(0, 1) ? 2 : 6 + $urandom_range(0, 2)), 5);
          put_fixed({$urandom} ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0));
        end
        3, 4: begin
          put_tag(($urandom_range(0, 1)) ? 9 : (($urandom_range(0, 1)) ? 10 : 12), 0);
          put_varint({$urandom, $urandom} >> $urandom_range(0, 63));
        end
        5, 6, 7: build_data($urandom_range(0, ($urandom_range(0, 9) == 0) ? 256 : 12));
        8: begin put_tag($urandom_range(13, 40), 2); put_varint(3);
                 repeat (3) pkt.push_back(8'($urandom)); end
        9: begin put_tag($urandom_range(13, 40), 1); put_fixed($urandom); put_fixed($urandom); end
        10: begin put_tag(3, 0); put_varint(64'($urandom)); end
        default: begin
          // noise: a random byte, which may break the packet
          pkt.push_back(8'($urandom));
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0 && pkt.size() > 1) void'(pkt.pop_back());
    if (pkt.size() == 0) pkt.push_back(8'h00);
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stim_done = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: fixed32 fields at their extremes and every known field.
    put_tag(1, 5); put_fixed(32'h0);
    put_tag(2, 5); put_fixed(32'hFFFF_FFFF);
    put_tag(6, 5); put_fixed(32'h1234_5678);
    put_tag(7, 5); put_fixed(32'h8000_0001);
    put_tag(8, 5); put_fixed(32'h7FFF_FFFF);
    put_tag(3, 0); put_varint(5);
    put_tag(9, 0); put_varint(64'hFFFF_FFFF_FFFF_FFFF);
    put_tag(10, 0); put_varint(0);
    put_tag(12, 0); put_varint(2);
    build_data(2);
    send_packet();
    // Empty data message, then a repeated one.
    put_tag(4, 2); put_varint(0); build_data(0); send_packet();
    // Varint too long.
    repeat (10) pkt.push_back(8'hFF); pkt.push_back(8'h01); send_packet();
    // Bad wire type, and field 4 with the wrong wire type.
    put_tag(20, 3); put_fixed(0); send_packet();
    put_tag(4, 0); pkt.push_back(8'h00); send_packet();
    // Huge field number, skipped as unknown.
    put_varint(64'hFFFF_FFF0_0000_0000); put_varint(7); send_packet();
    // Oversized length.
    put_tag(15, 2); put_varint(600); send_packet();
    // Payload too big.
    put_tag(4, 2); put_varint(300); put_tag(2, 2); put_varint(257); pkt.push_back(0);
    send_packet();
    // Nested overrun: inner length past the end, and a field cut by the end.
    put_tag(4, 2); put_varint(3); put_tag(2, 2); put_varint(5); pkt.push_back(0); send_packet();
    put_tag(4, 2); put_varint(2); put_tag(1, 0); pkt.push_back(8'h81); pkt.push_back(8'h01);
    send_packet();
    // Truncated inside a field, and the largest payload.
    put_tag(1, 5); pkt.push_back(8'hAA); send_packet();
    build_data(256); send_packet();

    // Random packets.
    sent = 0;
    while (sent < 450) begin
      build_random_packet();
      sent += pkt.size();
      send_packet();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
